### rtl/plm_pkg.sv
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types and constants of the peak level meter.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int unsigned LevelW     = 15;
  localparam int unsigned CountW     = 4;
  localparam int unsigned WeightW    = 16;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned RootSteps  = 16;

  localparam logic [CountW-1:0]  ChannelCountRst = 4'd2;
  localparam logic [WeightW-1:0] SmoothWeightRst = 16'd6554;

  typedef enum logic [CfgIdxW-1:0] {
    CfgChannelCount = 1'b0,
    CfgSmoothWeight = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] peak;
  } peak_push_t;

  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] peak;
  } peak_head_t;

endpackage

### rtl/plm_if.sv
// ----------------------------------------------------------------------------
// plm interfaces
// Valid/ready channels for samples, levels and register writes.
// ----------------------------------------------------------------------------
interface plm_sample_if #(
  parameter int unsigned SampleBits = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] sample;
  logic                         last_in_buffer;

  modport source (output valid, output sample, output last_in_buffer, input ready);
  modport sink   (input valid, input sample, input last_in_buffer, output ready);
endinterface

interface plm_level_if;
  logic                       valid;
  logic                       ready;
  logic [plm_pkg::LevelW-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface plm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [plm_pkg::CfgIdxW-1:0]  index;
  logic [plm_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/peak_level_meter_sqrt_smoothed.sv
// ----------------------------------------------------------------------------
// peak_level_meter_sqrt_smoothed
// First-channel peak meter with square-root scaling and one-pole smoothing.
//
//   port       dir   payload                         transaction
//   sample_i   in    sample, last_in_buffer          one interleaved sample
//   cfg_i      in    index, data                     one register write
//   level_o    out   level                           one level per buffer
//
// Samples are taken one per cycle while the peak queue has room.
// Each buffer end takes the back through a load, 16 root steps, a multiply
// and a blend; the two-entry queue absorbs bursts of short buffers.
// Reset clears peak, channel position, level and queue at once.
// A stalled level output holds the back at its blend step.
// ----------------------------------------------------------------------------
module peak_level_meter_sqrt_smoothed #(
  parameter int unsigned SampleBits = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  plm_sample_if.sink    sample_i,
  plm_cfg_if.sink       cfg_i,
  plm_level_if.source   level_o
);

  logic [plm_pkg::CountW-1:0]  channel_count_q;
  logic [plm_pkg::WeightW-1:0] smooth_weight_q;
  plm_pkg::peak_push_t         push;
  plm_pkg::peak_head_t         head;
  logic                        queue_full;
  logic                        pop;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= plm_pkg::ChannelCountRst;
      smooth_weight_q <= plm_pkg::SmoothWeightRst;
    end else if (cfg_i.valid) begin
      unique case (plm_pkg::cfg_reg_e'(cfg_i.index))
        plm_pkg::CfgChannelCount: channel_count_q <= cfg_i.data[plm_pkg::CountW-1:0];
        plm_pkg::CfgSmoothWeight: smooth_weight_q <= cfg_i.data[plm_pkg::WeightW-1:0];
        default: ;
      endcase
    end
  end

  plm_front #(
    .SampleBits (SampleBits)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sample_i        (sample_i),
    .channel_count_i (channel_count_q),
    .queue_full_i    (queue_full),
    .push_o          (push)
  );

  plm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (queue_full),
    .pop_i  (pop),
    .head_o (head)
  );

  plm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .pop_o           (pop),
    .smooth_weight_i (smooth_weight_q),
    .level_o         (level_o)
  );

endmodule

### rtl/plm_front.sv
// ----------------------------------------------------------------------------
// plm_front
// Accepts samples, tracks the first-channel peak, hands the peak of each
// finished buffer to the queue.
// ----------------------------------------------------------------------------
module plm_front #(
  parameter int unsigned SampleBits = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  plm_sample_if.sink                     sample_i,
  input  logic [plm_pkg::CountW-1:0]     channel_count_i,
  input  logic                           queue_full_i,
  output plm_pkg::peak_push_t            push_o
);

  logic [plm_pkg::LevelW-1:0] peak_q, peak_d;
  logic [2:0]                 pos_q, pos_d;
  logic                       accept;
  logic [SampleBits-1:0]      mag_raw;
  logic [SampleBits-2:0]      mag_sat;
  logic [plm_pkg::LevelW-1:0] mag15;
  logic [plm_pkg::LevelW-1:0] peak_new;
  logic [3:0]                 chans;
  logic [3:0]                 pos_inc;

  assign sample_i.ready = !queue_full_i;
  assign accept         = sample_i.valid && sample_i.ready;

  assign mag_raw = sample_i.sample[SampleBits-1] ? (~sample_i.sample + 1'b1)
                                                 : sample_i.sample;
  assign mag_sat = mag_raw[SampleBits-1] ? '1 : mag_raw[SampleBits-2:0];

  if (SampleBits >= 16) begin : g_narrow
    assign mag15 = mag_sat[SampleBits-2 -: plm_pkg::LevelW];
  end else begin : g_widen
    assign mag15 = {mag_sat, {(16 - SampleBits){1'b0}}};
  end

  always_comb begin
    priority if (channel_count_i == 4'd0) begin
      chans = 4'd1;
    end else if (channel_count_i > 4'd8) begin
      chans = 4'd8;
    end else begin
      chans = channel_count_i;
    end
  end

  assign peak_new = (pos_q == 3'd0 && mag15 > peak_q) ? mag15 : peak_q;
  assign pos_inc  = {1'b0, pos_q} + 4'd1;

  always_comb begin
    peak_d = peak_q;
    pos_d  = pos_q;
    if (accept) begin
      if (sample_i.last_in_buffer) begin
        peak_d = '0;
        pos_d  = '0;
      end else begin
        peak_d = peak_new;
        pos_d  = (pos_inc >= chans) ? 3'd0 : pos_inc[2:0];
      end
    end
  end

  assign push_o.valid = accept && sample_i.last_in_buffer;
  assign push_o.peak  = peak_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      pos_q  <= '0;
    end else begin
      peak_q <= peak_d;
      pos_q  <= pos_d;
    end
  end

endmodule

### rtl/plm_queue.sv
// ----------------------------------------------------------------------------
// plm_queue
// Short queue of buffer peaks between the front and the back.
// ----------------------------------------------------------------------------
module plm_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  plm_pkg::peak_push_t push_i,
  output logic                full_o,
  input  logic                pop_i,
  output plm_pkg::peak_head_t head_o
);

  localparam int unsigned PtrW = $clog2(plm_pkg::QueueDepth);

  logic [plm_pkg::LevelW-1:0] mem_q [plm_pkg::QueueDepth];
  logic [PtrW-1:0]            wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]              count_q;

  assign full_o      = count_q == (PtrW + 1)'(plm_pkg::QueueDepth);
  assign head_o.valid = count_q != '0;
  assign head_o.peak  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.peak;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(plm_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(plm_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i.valid, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("peak pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_o.valid)
    else $error("peak popped from empty queue");

endmodule

### rtl/plm_back.sv
// ----------------------------------------------------------------------------
// plm_back
// Takes the square root of each buffer peak, blends it into the running
// level and presents the level.
// ----------------------------------------------------------------------------
module plm_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  plm_pkg::peak_head_t         head_i,
  output logic                        pop_o,
  input  logic [plm_pkg::WeightW-1:0] smooth_weight_i,
  plm_level_if.source                 level_o
);

  typedef enum logic [1:0] {
    StIdle,
    StRoot,
    StMul,
    StBlend
  } state_e;

  state_e                     state_q;
  logic [29:0]                rem_q;
  logic [30:0]                res_q;
  logic [3:0]                 step_q;
  logic signed [32:0]         prod_q;
  logic [plm_pkg::LevelW-1:0] level_q;
  logic                       out_valid_q;

  logic [30:0]        bit_w;
  logic [31:0]        trial;
  logic               take;
  logic signed [15:0] diff;
  logic signed [17:0] blend_sum;
  logic               slot_free;

  assign bit_w = 31'd1 << {step_q, 1'b0};
  assign trial = {1'b0, res_q} + {1'b0, bit_w};
  assign take  = {2'b00, rem_q} >= trial;

  assign diff      = $signed({1'b0, res_q[14:0]}) - $signed({1'b0, level_q});
  assign blend_sum = $signed({3'b000, level_q}) + 18'($signed(prod_q[32:16]));
  assign slot_free = !out_valid_q || level_o.ready;

  assign pop_o         = (state_q == StIdle) && head_i.valid;
  assign level_o.valid = out_valid_q;
  assign level_o.level = level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rem_q       <= '0;
      res_q       <= '0;
      step_q      <= '0;
      prod_q      <= '0;
      level_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (level_o.ready && state_q != StBlend) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (head_i.valid) begin
            rem_q   <= {head_i.peak, 15'd0};
            res_q   <= '0;
            step_q  <= 4'(plm_pkg::RootSteps - 1);
            state_q <= StRoot;
          end
        end
        StRoot: begin
          if (take) begin
            rem_q <= rem_q - trial[29:0];
            res_q <= (res_q >> 1) + bit_w;
          end else begin
            res_q <= res_q >> 1;
          end
          if (step_q == 4'd0) begin
            state_q <= StMul;
          end else begin
            step_q <= step_q - 1'b1;
          end
        end
        StMul: begin
          prod_q  <= 33'(diff) * 33'($signed({1'b0, smooth_weight_i}));
          state_q <= StBlend;
        end
        StBlend: begin
          if (slot_free) begin
            level_q     <= blend_sum[14:0];
            out_valid_q <= 1'b1;
            state_q     <= StIdle;
          end else begin
            out_valid_q <= out_valid_q;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_root_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StMul |-> res_q[30:15] == '0)
    else $error("square root exceeds level range");

  a_level_only_on_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(level_q) |-> $past(state_q) == StBlend && $past(slot_free))
    else $error("level changed outside blend");

  a_blend_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StBlend && !slot_free |=> state_q == StBlend)
    else $error("blend left while output slot busy");

endmodule
